### design/chd_pkg.sv
// Package for the chapter heading detector: line phase type, character sets,
// byte constants and the set lookup functions.
// No dependencies.
package chd_pkg;

   // Byte constants
   localparam logic [7:0] SPACE_BYTE  = 8'h20;
   localparam logic [7:0] CR_BYTE     = 8'h0D;
   localparam logic [7:0] END_BYTE    = 8'h00;
   localparam logic [7:0] PFX_LEAD    = 8'hE7;
   localparam logic [7:0] PFX_TAIL    = 8'hAC;
   localparam logic [3:0] LEAD3_NIB   = 4'hE;
   localparam logic [7:0] DIGIT_LO    = 8'h30;
   localparam logic [7:0] DIGIT_HI    = 8'h39;

   // Title buffer capacity register
   localparam int unsigned CAP_W      = 9;
   localparam logic [CAP_W-1:0] CAP_RESET = 9'd64;
   localparam int unsigned LEN_W      = 8;
   localparam int unsigned SEEN_W     = 9;
   localparam logic [SEEN_W-1:0] SEEN_MAX = 9'd511;
   localparam logic [LEN_W-1:0] LEN_MAX = 8'd255;

   localparam int unsigned CP_W       = 16;
   localparam int unsigned NUM_COUNT  = 15;
   localparam int unsigned UNIT_COUNT = 7;

   localparam logic [CP_W-1:0] NUMERAL_SET [NUM_COUNT] = '{
      16'h3007, 16'h4E00, 16'h4E8C, 16'h4E09, 16'h56DB, 16'h4E94, 16'h516D, 16'h4E03,
      16'h516B, 16'h4E5D, 16'h5341, 16'h767E, 16'h5343, 16'h4E07, 16'h4E24
   };
   localparam logic [CP_W-1:0] UNIT_SET [UNIT_COUNT] = '{
      16'h5377, 16'h7AE0, 16'h56DE, 16'h8282, 16'h7BC7, 16'h90E8, 16'h96C6
   };

   // Line scan phase, one-hot
   typedef enum logic [5:0] {
      PH_SPACES  = 6'b000001,
      PH_PFX1    = 6'b000010,
      PH_PFX2    = 6'b000100,
      PH_NUMS    = 6'b001000,
      PH_MATCHED = 6'b010000,
      PH_FAILED  = 6'b100000
   } phase_type;

   // Position inside a 3-byte character
   typedef enum logic [1:0] {
      CB_LEAD   = 2'd0,
      CB_MIDDLE = 2'd1,
      CB_LAST   = 2'd2
   } char_pos_type;

   function automatic logic is_numeral(input logic [CP_W-1:0] cp);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < NUM_COUNT; i++) begin
         if (NUMERAL_SET[i] == cp) hit = 1'b1;
      end
      return hit;
   endfunction

   function automatic logic is_unit(input logic [CP_W-1:0] cp);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < UNIT_COUNT; i++) begin
         if (UNIT_SET[i] == cp) hit = 1'b1;
      end
      return hit;
   endfunction

endpackage

### design/chd_intf.sv
// Valid/ready channel interfaces for the chapter heading detector.
// Depends on chd_pkg for field widths.
interface chd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

interface chd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       is_title;
   logic [chd_pkg::LEN_W-1:0]  title_length;

   modport source (output valid, output is_title, output title_length, input ready);
   modport sink   (input valid, input is_title, input title_length, output ready);
endinterface

### design/chapter_heading_detector.sv
// Chapter heading detector top level: per-line scan state and result register.
// Depends on chd_pkg and the channel interfaces in chd_intf.sv.
//
//   Channel   Direction  Payload                     Transfer
//   req_ch    in         text_byte[7:0]              valid & ready
//   rsp_ch    out        is_title, title_length[7:0] valid & ready
//   csr_*     in         csr_wr_data[8:0]            csr_wr_en
//
// One byte is taken per cycle while req_ch.ready is high; a zero byte puts its result in the output
// register on the following cycle. req_ch.ready drops only while a result
// sits in the output register and rsp_ch.ready is low.
// Synchronous active-high reset clears the line state, empties the output
// register and sets title capacity to 64.
module chapter_heading_detector (
   input  logic                          clock,
   input  logic                          reset,
   chd_req_if.sink                       req_ch,
   chd_rsp_if.source                     rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [chd_pkg::CAP_W-1:0]     csr_wr_data
);

   chd_pkg::phase_type                phase_ff, phase_in;
   chd_pkg::char_pos_type             cpos_ff, cpos_in;
   logic [3:0]                        lead_ff, lead_in;
   logic [5:0]                        mid_ff, mid_in;
   logic                              seen_num_ff, seen_num_in;
   logic [chd_pkg::SEEN_W-1:0]        seen_ff, seen_in;
   logic [chd_pkg::LEN_W-1:0]         kept_ff, kept_in;
   logic [chd_pkg::LEN_W-1:0]         limit_ff, limit_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              is_title_ff, is_title_in;
   logic [chd_pkg::LEN_W-1:0]         title_len_ff, title_len_in;

   logic                              req_xfer;
   logic                              line_end;
   logic [7:0]                        c;
   logic [chd_pkg::CP_W-1:0]          cp;
   logic [chd_pkg::CAP_W-1:0]         cap_m1;

   assign c        = req_ch.text_byte;
   assign req_xfer = req_ch.valid && req_ch.ready;
   assign line_end = req_xfer && (c == chd_pkg::END_BYTE);
   assign cp       = {lead_ff, mid_ff, c[5:0]};

   // Output register handshake
   assign req_ch.ready        = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.is_title     = is_title_ff;
   assign rsp_ch.title_length = title_len_ff;

   // Kept-byte limit: min(capacity - 1, 255), zero for zero capacity
   always_comb begin
      cap_m1   = csr_wr_data - chd_pkg::CAP_W'(1);
      limit_in = limit_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0)
            limit_in = '0;
         else if (cap_m1 > chd_pkg::CAP_W'(chd_pkg::LEN_MAX))
            limit_in = chd_pkg::LEN_MAX;
         else
            limit_in = cap_m1[chd_pkg::LEN_W-1:0];
      end
   end

   // Line scan next state
   always_comb begin
      phase_in    = phase_ff;
      cpos_in     = cpos_ff;
      lead_in     = lead_ff;
      mid_in      = mid_ff;
      seen_num_in = seen_num_ff;
      seen_in     = seen_ff;
      kept_in     = kept_ff;
      if (line_end) begin
         phase_in    = chd_pkg::PH_SPACES;
         cpos_in     = chd_pkg::CB_LEAD;
         lead_in     = '0;
         mid_in      = '0;
         seen_num_in = 1'b0;
         seen_in     = '0;
         kept_in     = '0;
      end else if (req_xfer) begin
         // title length tracks the last kept non-blank byte
         if (seen_ff < chd_pkg::SEEN_W'(limit_ff) && c != chd_pkg::SPACE_BYTE &&
             c != chd_pkg::CR_BYTE)
            kept_in = seen_ff[chd_pkg::LEN_W-1:0] + chd_pkg::LEN_W'(1);
         if (seen_ff != chd_pkg::SEEN_MAX)
            seen_in = seen_ff + chd_pkg::SEEN_W'(1);

         unique case (phase_ff)
            chd_pkg::PH_SPACES: begin
               if (c == chd_pkg::SPACE_BYTE)    phase_in = chd_pkg::PH_SPACES;
               else if (c == chd_pkg::PFX_LEAD) phase_in = chd_pkg::PH_PFX1;
               else                             phase_in = chd_pkg::PH_FAILED;
            end
            chd_pkg::PH_PFX1: begin
               phase_in = (c == chd_pkg::PFX_TAIL) ? chd_pkg::PH_PFX2 : chd_pkg::PH_FAILED;
            end
            chd_pkg::PH_PFX2: begin
               phase_in = (c == chd_pkg::PFX_TAIL) ? chd_pkg::PH_NUMS : chd_pkg::PH_FAILED;
            end
            chd_pkg::PH_NUMS: begin
               unique case (cpos_ff)
                  chd_pkg::CB_LEAD: begin
                     if (c >= chd_pkg::DIGIT_LO && c <= chd_pkg::DIGIT_HI) begin
                        seen_num_in = 1'b1;
                     end else if (c[7:4] == chd_pkg::LEAD3_NIB) begin
                        lead_in = c[3:0];
                        cpos_in = chd_pkg::CB_MIDDLE;
                     end else begin
                        phase_in = chd_pkg::PH_FAILED;
                     end
                  end
                  chd_pkg::CB_MIDDLE: begin
                     mid_in  = c[5:0];
                     cpos_in = chd_pkg::CB_LAST;
                  end
                  chd_pkg::CB_LAST: begin
                     cpos_in = chd_pkg::CB_LEAD;
                     if (chd_pkg::is_numeral(cp))
                        seen_num_in = 1'b1;
                     else if (seen_num_ff && chd_pkg::is_unit(cp))
                        phase_in = chd_pkg::PH_MATCHED;
                     else
                        phase_in = chd_pkg::PH_FAILED;
                  end
                  default: phase_in = chd_pkg::PH_FAILED;
               endcase
            end
            chd_pkg::PH_MATCHED, chd_pkg::PH_FAILED: begin
               phase_in = phase_ff;
            end
            default: phase_in = chd_pkg::PH_FAILED;
         endcase
      end
   end

   // Result register load and drain
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      is_title_in  = is_title_ff;
      title_len_in = title_len_ff;
      if (rsp_valid_ff && rsp_ch.ready) rsp_valid_in = 1'b0;
      if (line_end) begin
         rsp_valid_in = 1'b1;
         is_title_in  = (phase_ff == chd_pkg::PH_MATCHED);
         title_len_in = (phase_ff == chd_pkg::PH_MATCHED) ? kept_ff : '0;
      end
   end

   // Control and line state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= chd_pkg::PH_SPACES;
         cpos_ff      <= chd_pkg::CB_LEAD;
         lead_ff      <= '0;
         mid_ff       <= '0;
         seen_num_ff  <= 1'b0;
         seen_ff      <= '0;
         kept_ff      <= '0;
         limit_ff     <= chd_pkg::LEN_W'(chd_pkg::CAP_RESET - chd_pkg::CAP_W'(1));
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         cpos_ff      <= cpos_in;
         lead_ff      <= lead_in;
         mid_ff       <= mid_in;
         seen_num_ff  <= seen_num_in;
         seen_ff      <= seen_in;
         kept_ff      <= kept_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      is_title_ff  <= is_title_in;
      title_len_ff <= title_len_in;
   end

   // Checks
   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      line_end |=> rsp_valid_ff)
      else $error("line end did not load a result");

   a_end_clears_line: assert property (@(posedge clock) disable iff (reset)
      line_end |=> (seen_ff == '0 && kept_ff == '0 && phase_ff == chd_pkg::PH_SPACES))
      else $error("line state not cleared after line end");

   a_no_title_no_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !is_title_ff) |-> (title_len_ff == '0))
      else $error("nonzero length on a non-heading line");

   a_kept_bounded: assert property (@(posedge clock) disable iff (reset)
      (chd_pkg::SEEN_W'(kept_ff) <= seen_ff) && (kept_ff <= limit_ff || kept_ff == '0))
      else $error("kept length beyond bytes seen or limit");

endmodule
